// ----- rtl/core/fragment_shade_fog_blend_top_assert.svh -----
// Assertion macros for the fragment shade, fog and blend pipeline.
`ifndef FRAGMENT_SHADE_FOG_BLEND_TOP_ASSERT_SVH
`define FRAGMENT_SHADE_FOG_BLEND_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off during reset
`define FSFB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FSFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/fsfb_pkg.sv -----
// Shared constants and helper functions for the fragment shade, fog and blend pipeline.
package fsfb_pkg;

    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 56;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_TINT_COLOUR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_COLOUR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_NEAR    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_FAR     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH_TEST  = 3'd4;

    localparam logic [7:0] ALPHA_MIN    = 8'd8;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // saturated colour width ahead of the blend; wide enough that the final clamp is unchanged
    localparam int BLEND_W = 15;
    localparam int BLEND_MAX = 16383;
    localparam int BLEND_MIN = -16384;
    localparam int NUM_W = 25;
    localparam int DIV255_LIMIT = 65280;

    // floor(x / 255) for x up to 65279
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = 17'(x) + 17'(x[15:8]) + 17'd1;
        return t[15:8];
    endfunction

    function automatic logic [7:0] sat_byte(input logic signed [BLEND_W-1:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 255)
            r = 8'hFF;
        else
            r = v[7:0];
        return r;
    endfunction

endpackage

// ----- rtl/core/fsfb_div_pipe.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
module fsfb_div_pipe #(
    parameter int STEPS = 33,
    parameter int RW = 32,
    parameter int DW = 31,
    parameter int SW = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic             in_valid,
    input  logic [RW-1:0]    in_rem,
    input  logic [DW-1:0]    in_den,
    input  logic [STEPS-1:0] in_num,
    input  logic [SW-1:0]    in_side,
    output logic             out_valid,
    output logic [STEPS-1:0] out_quo,
    output logic [SW-1:0]    out_side
);

    logic             valid_reg [STEPS];
    logic [RW-1:0]    rem_reg   [STEPS];
    logic [DW-1:0]    den_reg   [STEPS];
    logic [STEPS-1:0] num_reg   [STEPS];
    logic [STEPS-1:0] quo_reg   [STEPS];
    logic [SW-1:0]    side_reg  [STEPS];

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic             src_valid;
        logic [RW-1:0]    src_rem;
        logic [DW-1:0]    src_den;
        logic [STEPS-1:0] src_num;
        logic [STEPS-1:0] src_quo;
        logic [SW-1:0]    src_side;
        logic [RW-1:0]    trial;
        logic [RW-1:0]    den_ext;
        logic             take;

        if (k == 0) begin : g_first
            assign src_valid = in_valid;
            assign src_rem   = in_rem;
            assign src_den   = in_den;
            assign src_num   = in_num;
            assign src_quo   = '0;
            assign src_side  = in_side;
        end
        else begin : g_next
            assign src_valid = valid_reg[k-1];
            assign src_rem   = rem_reg[k-1];
            assign src_den   = den_reg[k-1];
            assign src_num   = num_reg[k-1];
            assign src_quo   = quo_reg[k-1];
            assign src_side  = side_reg[k-1];
        end

        assign trial   = {src_rem[RW-2:0], src_num[STEPS-1]};
        assign den_ext = {{(RW-DW){1'b0}}, src_den};
        assign take    = (trial >= den_ext);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[k] <= 1'b0;
            else if (advance)
                valid_reg[k] <= src_valid;
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                rem_reg[k]  <= take ? (trial - den_ext) : trial;
                den_reg[k]  <= src_den;
                num_reg[k]  <= {src_num[STEPS-2:0], 1'b0};
                quo_reg[k]  <= {src_quo[STEPS-2:0], take};
                side_reg[k] <= src_side;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_quo   = quo_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule

// ----- rtl/core/fragment_shade_fog_blend_top.sv -----
// Throughput: one item per cycle while the output is not stalled; the fog distance
// divider (2F+1 stages) and the fog factor divider (F stages) are fully pipelined,
// one quotient bit per stage.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n, async low) clears all valid bits and loads the register defaults.
module fragment_shade_fog_blend_top #(
    parameter int INTERP_FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fsfb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fsfb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // frag_depth, light_level, texel_colour, stored_depth, stored_colour
    input  logic [fsfb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // texture_present
    input  logic                             s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // colour_out, depth_out
    output logic [fsfb_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // colour_write, depth_write
    output logic [1:0]                       m_axis_tuser
);

    localparam int F   = INTERP_FRAC_BITS;
    localparam int CHW = 41 - F;
    localparam int DLW = CHW + 1;
    localparam int PW  = DLW + F + 2;
    localparam int DQW = 2 * F + 1;
    localparam int DFW = ((2 * F + 2 > 32) ? (2 * F + 2) : 32) + 1;
    localparam logic [DQW-1:0] DQ_NUM = {1'b1, {(DQW-1){1'b0}}};
    localparam logic [F:0] FT_ONE = {1'b1, {F{1'b0}}};

    typedef struct packed {
        logic                  kill;
        logic                  dwr;
        logic                  fog_on;
        logic [7:0]            ca;
        logic [31:0]           z;
        logic [23:0]           old;
        logic [2:0][CHW-1:0]   ch;
    } side1_t;

    typedef struct packed {
        logic                  kill;
        logic                  dwr;
        logic                  fog_on;
        logic [7:0]            ca;
        logic [31:0]           z;
        logic [23:0]           old;
        logic [2:0][CHW-1:0]   ch;
        logic [2:0][DLW-1:0]   delta;
        logic [DFW-1:0]        diff;
        logic [32:0]           den;
    } s3_t;

    typedef struct packed {
        logic                  kill;
        logic                  dwr;
        logic                  zero;
        logic                  full;
        logic [7:0]            ca;
        logic [31:0]           z;
        logic [23:0]           old;
        logic [2:0][CHW-1:0]   ch;
        logic [2:0][DLW-1:0]   delta;
    } side2_t;

    // configuration
    logic [31:0]        tint_reg;
    logic [23:0]        fogc_reg;
    logic signed [31:0] near_reg;
    logic signed [31:0] far_reg;
    logic               dte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tint_reg <= 32'hFFFF_FFFF;
            fogc_reg <= '0;
            near_reg <= '0;
            far_reg  <= '0;
            dte_reg  <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fsfb_pkg::REG_TINT_COLOUR: tint_reg <= cfg_data;
                fsfb_pkg::REG_FOG_COLOUR:  fogc_reg <= cfg_data[23:0];
                fsfb_pkg::REG_FOG_NEAR:    near_reg <= cfg_data;
                fsfb_pkg::REG_FOG_FAR:     far_reg  <= cfg_data;
                fsfb_pkg::REG_DEPTH_TEST:  dte_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;

    assign adv = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 0: input register
    logic               v0_reg;
    logic signed [31:0] z0_reg;
    logic signed [31:0] li0_reg;
    logic               te0_reg;
    logic [31:0]        tc0_reg;
    logic signed [31:0] zs0_reg;
    logic [23:0]        old0_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            z0_reg   <= s_axis_tdata[31:0];
            li0_reg  <= s_axis_tdata[63:32];
            tc0_reg  <= s_axis_tdata[95:64];
            zs0_reg  <= s_axis_tdata[127:96];
            old0_reg <= s_axis_tdata[151:128];
            te0_reg  <= s_axis_tuser;
        end
    end

    // stage 1: depth test, tint modulation
    logic               v1_reg;
    logic               kill1_reg;
    logic               fog1_reg;
    logic [7:0]         ca1_reg;
    logic [7:0]         c1_reg [3];
    logic signed [31:0] z1_reg;
    logic signed [31:0] li1_reg;
    logic [23:0]        old1_reg;

    logic [7:0] ca1_next;
    logic [7:0] c1_next [3];
    logic       kill1_next;
    logic       fog1_next;

    always_comb
    begin
        ca1_next = te0_reg ? fsfb_pkg::div255(16'(tc0_reg[31:24]) * 16'(tint_reg[31:24]))
                           : tint_reg[31:24];
        for (int i = 0; i < 3; i++)
        begin
            c1_next[i] = te0_reg
                ? fsfb_pkg::div255(16'(tc0_reg[23-8*i -: 8]) * 16'(tint_reg[23-8*i -: 8]))
                : tint_reg[23-8*i -: 8];
        end
        kill1_next = (dte_reg && (z0_reg <= zs0_reg)) || (ca1_next < fsfb_pkg::ALPHA_MIN);
        fog1_next  = (far_reg > near_reg) && (z0_reg > 0);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kill1_reg <= kill1_next;
            fog1_reg  <= fog1_next;
            ca1_reg   <= ca1_next;
            c1_reg    <= c1_next;
            z1_reg    <= z0_reg;
            li1_reg   <= li0_reg;
            old1_reg  <= old0_reg;
        end
    end

    // stage 2: lighting
    logic               v2_reg;
    side1_t             s2_reg;
    logic signed [40:0] prod2 [3];
    side1_t             s2_next;

    always_comb
    begin
        s2_next.kill   = kill1_reg;
        s2_next.dwr    = dte_reg;
        s2_next.fog_on = fog1_reg;
        s2_next.ca     = ca1_reg;
        s2_next.z      = z1_reg;
        s2_next.old    = old1_reg;
        for (int i = 0; i < 3; i++)
        begin
            prod2[i] = $signed({1'b0, c1_reg[i]}) * li1_reg;
            s2_next.ch[i] = prod2[i][40:F];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s2_reg <= s2_next;
    end

    // fog distance: 2^(2F) / z
    logic           d1_valid;
    logic [DQW-1:0] d1_quo;
    logic [$bits(side1_t)-1:0] d1_side;

    fsfb_div_pipe #(
        .STEPS(DQW),
        .RW(32),
        .DW(31),
        .SW($bits(side1_t))
    ) u_dist_div (
        .clk(clk),
        .rst_n(rst_n),
        .advance(adv),
        .in_valid(v2_reg),
        .in_rem(32'd0),
        .in_den(s2_reg.z[30:0]),
        .in_num(DQ_NUM),
        .in_side(s2_reg),
        .out_valid(d1_valid),
        .out_quo(d1_quo),
        .out_side(d1_side)
    );

    // stage 3: distance minus near, fog range, fog deltas
    logic   v3_reg;
    s3_t    s3_reg;
    s3_t    s3_next;
    side1_t d1_s;

    always_comb
    begin
        d1_s = side1_t'(d1_side);
        s3_next.kill   = d1_s.kill;
        s3_next.dwr    = d1_s.dwr;
        s3_next.fog_on = d1_s.fog_on;
        s3_next.ca     = d1_s.ca;
        s3_next.z      = d1_s.z;
        s3_next.old    = d1_s.old;
        s3_next.ch     = d1_s.ch;
        s3_next.diff   = $signed({{(DFW-DQW){1'b0}}, d1_quo})
                       - $signed({{(DFW-32){near_reg[31]}}, near_reg});
        s3_next.den    = $signed({far_reg[31], far_reg}) - $signed({near_reg[31], near_reg});
        for (int i = 0; i < 3; i++)
        begin
            s3_next.delta[i] = $signed({{(DLW-8){1'b0}}, fogc_reg[23-8*i -: 8]})
                             - $signed({d1_s.ch[i][CHW-1], d1_s.ch[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            s3_reg <= s3_next;
    end

    // stage 4: clamp decisions, divider operands
    logic        v4_reg;
    side2_t      s4_reg;
    logic [32:0] rem4_reg;
    logic [31:0] den4_reg;
    side2_t      s4_next;
    logic        zero4;
    logic        full4;

    always_comb
    begin
        zero4 = !s3_reg.fog_on || ($signed(s3_reg.diff) <= 0);
        full4 = !zero4 && ($signed(s3_reg.diff) >= $signed(s3_reg.den));
        s4_next.kill  = s3_reg.kill;
        s4_next.dwr   = s3_reg.dwr;
        s4_next.zero  = zero4;
        s4_next.full  = full4;
        s4_next.ca    = s3_reg.ca;
        s4_next.z     = s3_reg.z;
        s4_next.old   = s3_reg.old;
        s4_next.ch    = s3_reg.ch;
        s4_next.delta = s3_reg.delta;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg   <= s4_next;
            rem4_reg <= (zero4 || full4) ? 33'd0 : {1'b0, s3_reg.diff[31:0]};
            den4_reg <= s3_reg.den[31:0];
        end
    end

    // fog factor: diff * 2^F / (far - near), below one here
    logic         d2_valid;
    logic [F-1:0] d2_quo;
    logic [$bits(side2_t)-1:0] d2_side;

    fsfb_div_pipe #(
        .STEPS(F),
        .RW(33),
        .DW(32),
        .SW($bits(side2_t))
    ) u_fog_div (
        .clk(clk),
        .rst_n(rst_n),
        .advance(adv),
        .in_valid(v4_reg),
        .in_rem(rem4_reg),
        .in_den(den4_reg),
        .in_num({F{1'b0}}),
        .in_side(s4_reg),
        .out_valid(d2_valid),
        .out_quo(d2_quo),
        .out_side(d2_side)
    );

    // stage 5: fog product
    logic               v5_reg;
    logic               kill5_reg;
    logic               dwr5_reg;
    logic [7:0]         ca5_reg;
    logic [31:0]        z5_reg;
    logic [23:0]        old5_reg;
    logic [2:0][CHW-1:0] ch5_reg;
    logic signed [PW-1:0] p5_reg [3];
    logic signed [PW-1:0] p5_next [3];
    side2_t             d2_s;
    logic [F:0]         ft5;

    always_comb
    begin
        d2_s = side2_t'(d2_side);
        ft5 = d2_s.zero ? '0 : (d2_s.full ? FT_ONE : {1'b0, d2_quo});
        for (int i = 0; i < 3; i++)
            p5_next[i] = $signed(d2_s.delta[i]) * $signed({1'b0, ft5});
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kill5_reg <= d2_s.kill;
            dwr5_reg  <= d2_s.dwr;
            ca5_reg   <= d2_s.ca;
            z5_reg    <= d2_s.z;
            old5_reg  <= d2_s.old;
            ch5_reg   <= d2_s.ch;
            p5_reg    <= p5_next;
        end
    end

    // stage 6: fog mix, saturate for blend
    logic        v6_reg;
    logic        kill6_reg;
    logic        dwr6_reg;
    logic [7:0]  ca6_reg;
    logic [31:0] z6_reg;
    logic [23:0] old6_reg;
    logic signed [fsfb_pkg::BLEND_W-1:0] sc6_reg  [3];
    logic signed [fsfb_pkg::BLEND_W-1:0] sc6_next [3];
    logic signed [PW-1:0] mix6 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mix6[i] = (p5_reg[i] >>> F) + $signed(ch5_reg[i]);
            if (mix6[i] > fsfb_pkg::BLEND_MAX)
                sc6_next[i] = fsfb_pkg::BLEND_W'(fsfb_pkg::BLEND_MAX);
            else if (mix6[i] < fsfb_pkg::BLEND_MIN)
                sc6_next[i] = fsfb_pkg::BLEND_W'(fsfb_pkg::BLEND_MIN);
            else
                sc6_next[i] = mix6[i][fsfb_pkg::BLEND_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kill6_reg <= kill5_reg;
            dwr6_reg  <= dwr5_reg;
            ca6_reg   <= ca5_reg;
            z6_reg    <= z5_reg;
            old6_reg  <= old5_reg;
            sc6_reg   <= sc6_next;
        end
    end

    // stage 7: blend numerator
    logic        v7_reg;
    logic        kill7_reg;
    logic        dwr7_reg;
    logic        opq7_reg;
    logic [31:0] z7_reg;
    logic signed [fsfb_pkg::BLEND_W-1:0] sc7_reg [3];
    logic signed [fsfb_pkg::NUM_W-1:0]   num7_reg  [3];
    logic signed [fsfb_pkg::NUM_W-1:0]   num7_next [3];
    logic signed [fsfb_pkg::NUM_W-2:0]   fa7 [3];
    logic [15:0] fb7 [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            fa7[i] = sc6_reg[i] * $signed({1'b0, ca6_reg});
            fb7[i] = 16'(old6_reg[23-8*i -: 8]) * 16'(fsfb_pkg::ALPHA_OPAQUE - ca6_reg);
            num7_next[i] = $signed({fa7[i][fsfb_pkg::NUM_W-2], fa7[i]})
                         + $signed({{(fsfb_pkg::NUM_W-16){1'b0}}, fb7[i]});
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            kill7_reg <= kill6_reg;
            dwr7_reg  <= dwr6_reg;
            opq7_reg  <= (ca6_reg == fsfb_pkg::ALPHA_OPAQUE);
            z7_reg    <= z6_reg;
            sc7_reg   <= sc6_reg;
            num7_reg  <= num7_next;
        end
    end

    // stage 8: divide by 255, clamp, output register
    logic        cw_reg;
    logic        dw_reg;
    logic [23:0] col_reg;
    logic [31:0] dout_reg;
    logic [7:0]  byte8 [3];
    logic [23:0] col_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (opq7_reg)
                byte8[i] = fsfb_pkg::sat_byte(sc7_reg[i]);
            else if (num7_reg[i] < 0)
                byte8[i] = 8'd0;
            else if (num7_reg[i] >= fsfb_pkg::DIV255_LIMIT)
                byte8[i] = 8'hFF;
            else
                byte8[i] = fsfb_pkg::div255(num7_reg[i][15:0]);
        end
        col_next = kill7_reg ? 24'd0 : {byte8[0], byte8[1], byte8[2]};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cw_reg   <= !kill7_reg;
            dw_reg   <= !kill7_reg && dwr7_reg;
            col_reg  <= col_next;
            dout_reg <= (!kill7_reg && dwr7_reg) ? z7_reg : 32'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            v6_reg      <= 1'b0;
            v7_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg      <= s_axis_tvalid;
            v1_reg      <= v0_reg;
            v2_reg      <= v1_reg;
            v3_reg      <= d1_valid;
            v4_reg      <= v3_reg;
            v5_reg      <= d2_valid;
            v6_reg      <= v5_reg;
            v7_reg      <= v6_reg;
            m_valid_reg <= v7_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {dout_reg, col_reg};
    assign m_axis_tuser  = {dw_reg, cw_reg};

    logic [2:0] front_valid;
    logic       kill_out;
    logic       depth_wr_out;

    assign front_valid  = {v0_reg, v1_reg, v2_reg};
    assign kill_out     = m_axis_tvalid && !m_axis_tuser[0];
    assign depth_wr_out = m_axis_tvalid && m_axis_tuser[1];

`include "fragment_shade_fog_blend_top_assert.svh"

    `FSFB_ASSERT_NOW(a_kill_no_write, kill_out, (!m_axis_tuser[1] && m_axis_tdata == '0), "killed item writes")
    `FSFB_ASSERT_NOW(a_depth_needs_colour, depth_wr_out, m_axis_tuser[0], "depth write without colour write")
    `FSFB_ASSERT_NEXT(a_stall_freezes, !s_axis_tready, $stable(front_valid), "pipeline moved during stall")

endmodule

// ----- tb/sv/fragment_shade_fog_blend_top_test.sv -----
// Self-checking stream testbench for the fragment shade, fog and blend pipeline.
`timescale 1ns / 1ps

module fragment_shade_fog_blend_top_test;

    localparam int FRAC = 16;
    localparam int PIPE_LATENCY = 3 * FRAC + 10;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic        colour_write;
        logic [23:0] colour_out;
        logic        depth_write;
        logic [31:0] depth_out;
    } pixel_write_t;

    class pixel_scoreboard;
        logic [31:0] tint;
        logic [23:0] fog_rgb;
        longint      near_dist;
        longint      far_dist;
        logic        depth_en;
        pixel_write_t pending[$];
        int          errors;

        function new();
            tint = 32'hFFFF_FFFF;
            fog_rgb = 24'd0;
            near_dist = 0;
            far_dist = 0;
            depth_en = 1'b1;
            errors = 0;
        endfunction

        task report(input string what, input longint got, input longint want);
            $display("MISMATCH %s: got 0x%0h expected 0x%0h at %0t", what, got, want, $realtime);
            errors++;
        endtask

        function void write_reg(input logic [fsfb_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
            case (idx)
                fsfb_pkg::REG_TINT_COLOUR: tint = v;
                fsfb_pkg::REG_FOG_COLOUR:  fog_rgb = v[23:0];
                fsfb_pkg::REG_FOG_NEAR:    near_dist = longint'($signed(v));
                fsfb_pkg::REG_FOG_FAR:     far_dist = longint'($signed(v));
                fsfb_pkg::REG_DEPTH_TEST:  depth_en = v[0];
                default: ;
            endcase
        endfunction

        function void note_fragment(input logic [fsfb_pkg::IN_DATA_W-1:0] d, input logic tex);
            longint z, li, zs, ca, c, tn, fog_dist, num, ft, o;
            longint ch[3];
            logic [31:0] tc;
            logic [23:0] old;
            pixel_write_t r;
            int sh;
            z = longint'($signed(d[31:0]));
            li = longint'($signed(d[63:32]));
            tc = d[95:64];
            zs = longint'($signed(d[127:96]));
            old = d[151:128];
            r = '0;
            if (depth_en && z <= zs)
            begin
                pending.push_back(r);
                return;
            end
            ca = tex ? longint'(tc[31:24]) * longint'(tint[31:24]) / 255 : longint'(tint[31:24]);
            if (ca < longint'(fsfb_pkg::ALPHA_MIN))
            begin
                pending.push_back(r);
                return;
            end
            for (int i = 0; i < 3; i++)
            begin
                sh = 16 - 8 * i;
                tn = longint'((tint >> sh) & 32'hFF);
                c = tex ? longint'((tc >> sh) & 32'hFF) * tn / 255 : tn;
                ch[i] = (c * li) >>> FRAC;
            end
            if (far_dist > near_dist && z > 0)
            begin
                fog_dist = (64'sd1 <<< (2 * FRAC)) / z;
                num = (fog_dist - near_dist) * (64'sd1 <<< FRAC);
                ft = num / (far_dist - near_dist);
                if (ft < 0)
                    ft = 0;
                if (ft > (64'sd1 <<< FRAC))
                    ft = 64'sd1 <<< FRAC;
                for (int i = 0; i < 3; i++)
                begin
                    sh = 16 - 8 * i;
                    ch[i] = ch[i] + (((longint'((fog_rgb >> sh) & 24'hFF) - ch[i]) * ft) >>> FRAC);
                end
            end
            if (ca < 255)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    sh = 16 - 8 * i;
                    o = longint'((old >> sh) & 24'hFF);
                    ch[i] = (ch[i] * ca + o * (255 - ca)) / 255;
                end
            end
            for (int i = 0; i < 3; i++)
                if (ch[i] < 0)
                    ch[i] = 0;
                else if (ch[i] > 255)
                    ch[i] = 255;
            r.colour_write = 1'b1;
            r.colour_out = {ch[0][7:0], ch[1][7:0], ch[2][7:0]};
            if (depth_en)
            begin
                r.depth_write = 1'b1;
                r.depth_out = d[31:0];
            end
            pending.push_back(r);
        endfunction

        task check_result(input logic [fsfb_pkg::OUT_DATA_W-1:0] d, input logic [1:0] u);
            pixel_write_t w;
            if (pending.size() == 0)
            begin
                report("unexpected item", 64'(d), 64'd0);
                return;
            end
            w = pending.pop_front();
            if (u[0] !== w.colour_write)
                report("colour_write", 64'(u[0]), 64'(w.colour_write));
            if (d[23:0] !== w.colour_out)
                report("colour_out", 64'(d[23:0]), 64'(w.colour_out));
            if (u[1] !== w.depth_write)
                report("depth_write", 64'(u[1]), 64'(w.depth_write));
            if (d[55:24] !== w.depth_out)
                report("depth_out", 64'(d[55:24]), 64'(w.depth_out));
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [fsfb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [fsfb_pkg::CFG_DATA_W-1:0] cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [fsfb_pkg::IN_DATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [fsfb_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0] m_axis_tuser;

    pixel_scoreboard sb;
    int cycles = 0;
    int burst_left;
    int stall_left = 0;
    int stall_mode = 0;

    fragment_shade_fog_blend_top dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_fragment(s_axis_tdata, s_axis_tuser);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tuser);
    end

    // receiver: runs of always-ready, random stalls and long stalls
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(5, 60);
        end
        stall_left--;
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task write_reg(input logic [fsfb_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] v);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        sb.write_reg(idx, v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task send_fragment(input logic [31:0] z, input logic [31:0] li, input logic tex,
                       input logic [31:0] tc, input logic [31:0] zs, input logic [23:0] old);
        if (burst_left == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {old, zs, tc, li, z};
        s_axis_tuser <= tex;
        do
            @(posedge clk);
        while (!s_axis_tready);
        @(negedge clk);
    endtask

    task random_fragment();
        logic [31:0] z, li, zs;
        case ($urandom_range(0, 3))
            0: z = $urandom;
            1: z = $urandom_range(1, 32'h0004_0000);
            default: z = $urandom_range(32'h0000_4000, 32'h0002_0000);
        endcase
        case ($urandom_range(0, 3))
            0: li = $urandom;
            1: li = -$urandom_range(0, 32'h0002_0000);
            default: li = $urandom_range(0, 32'h0002_0000);
        endcase
        case ($urandom_range(0, 3))
            0: zs = $urandom;
            1: zs = z;
            default: zs = z - $urandom_range(1, 1000);
        endcase
        send_fragment(z, li, 1'($urandom_range(0, 1)), $urandom, zs, 24'($urandom));
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (PIPE_LATENCY + 12) @(negedge clk);
    endtask

    initial
    begin
        logic [31:0] n, f;
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed items at reset settings
        send_fragment(32'h0001_0000, 32'h0001_0000, 1'b0, 32'h0, 32'h0001_0000, 24'h0);
        send_fragment(32'h7FFF_FFFF, 32'h0001_0000, 1'b1, 32'hFFFF_FFFF, 32'h8000_0000, 24'h0);
        send_fragment(32'h8000_0000, 32'h0001_0000, 1'b0, 32'h0, 32'h7FFF_FFFF, 24'hFF_FFFF);
        send_fragment(32'h0000_0002, 32'h0001_0000, 1'b1, 32'h07FF_FFFF, 32'h1, 24'h123456);
        send_fragment(32'h0000_0002, 32'h0000_8000, 1'b1, 32'h0800_FFFF, 32'h1, 24'hABCDEF);
        send_fragment(32'h0000_0002, 32'h0000_8000, 1'b1, 32'h8012_3456, 32'h1, 24'hFF_FFFF);
        send_fragment(32'h0000_0002, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, 32'h1, 24'h0);
        send_fragment(32'h0000_0002, 32'hFFFF_0000, 1'b0, 32'h0, 32'h1, 24'h0);
        send_fragment(32'h0000_0002, 32'h8000_0000, 1'b1, 32'hFF80_8080, 32'h1, 24'h0);
        send_fragment(32'h0000_0002, 32'h7FFF_FFFF, 1'b1, 32'hFF01_0203, 32'h1, 24'h0);
        send_fragment(32'h0000_0002, 32'h0002_0000, 1'b1, 32'hFEFF_FFFF, 32'h1, 24'h0);
        send_fragment(32'h0000_0001, 32'h0001_0000, 1'b1, 32'h0000_0000, 32'h0, 24'hFF_FFFF);
        send_fragment(32'hFFFF_FFFF, 32'h0001_0000, 1'b0, 32'h0, 32'hFFFF_FFFE, 24'h0);
        drain();

        for (int phase = 0; phase < 9; phase++)
        begin
            case (phase)
                0:
                begin
                    write_reg(fsfb_pkg::REG_TINT_COLOUR, 32'h0000_0000);
                    write_reg(fsfb_pkg::REG_DEPTH_TEST, 32'd0);
                end
                1:
                begin
                    write_reg(fsfb_pkg::REG_TINT_COLOUR, 32'hFFFF_FFFF);
                    write_reg(fsfb_pkg::REG_FOG_COLOUR, 32'h00FF_FFFF);
                    write_reg(fsfb_pkg::REG_FOG_NEAR, 32'h8000_0000);
                    write_reg(fsfb_pkg::REG_FOG_FAR, 32'h7FFF_FFFF);
                    write_reg(fsfb_pkg::REG_DEPTH_TEST, 32'd1);
                end
                2:
                begin
                    write_reg(fsfb_pkg::REG_FOG_NEAR, 32'h0001_0000);
                    write_reg(fsfb_pkg::REG_FOG_FAR, 32'h0001_0000);
                end
                3:
                begin
                    write_reg(fsfb_pkg::REG_FOG_NEAR, 32'h0001_0000);
                    write_reg(fsfb_pkg::REG_FOG_FAR, 32'h0000_0000);
                    write_reg(fsfb_pkg::REG_DEPTH_TEST, 32'd0);
                end
                default:
                begin
                    n = $urandom_range(0, 32'h0003_0000) - 32'h0001_0000;
                    f = n + $urandom_range(1, 32'h0004_0000);
                    write_reg(fsfb_pkg::REG_TINT_COLOUR, $urandom);
                    write_reg(fsfb_pkg::REG_FOG_COLOUR, $urandom);
                    write_reg(fsfb_pkg::REG_FOG_NEAR, n);
                    write_reg(fsfb_pkg::REG_FOG_FAR, f);
                    write_reg(fsfb_pkg::REG_DEPTH_TEST, $urandom_range(0, 1));
                end
            endcase
            repeat (65) random_fragment();
            drain();
        end

        s_axis_tvalid <= 1'b0;
        if (sb.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
